// File: src/tcw_pkg.sv
// Package for the text console character writer.
// Item types, character codes, fill words and parameter defaults.
// No dependencies.
package tcw_pkg;

    localparam int DEF_COLUMNS      = 80;
    localparam int DEF_SCROLL_ROWS  = 24;
    localparam int DEF_MEMORY_WORDS = 8192;

    localparam int FIELD_ADDR_W = 13;

    localparam logic [15:0] BLANK_WORD  = 16'h0700;
    localparam logic [15:0] SCROLL_FILL = 16'h0C00;
    localparam logic [7:0]  ATTR_RESET  = 8'd14;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  char_code;
        logic [12:0] read_address;
    } t_in_item;

    typedef struct packed {
        logic [12:0] cursor_address;
        logic [12:0] display_origin;
        logic [15:0] read_data;
    } t_out_item;

endpackage

// File: src/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/tcw_addr_unit.sv
// Shared word-address unit: base plus offset, wrapped modulo the memory size.
// Operands must sum to less than twice the memory size. No dependencies.
module tcw_addr_unit #(
    parameter int SW           = 13,
    parameter int MEMORY_WORDS = 8192
) (
    input  logic [SW-1:0]                   i_base,
    input  logic [SW-1:0]                   i_offset,
    output logic [$clog2(MEMORY_WORDS)-1:0] o_addr
);

    localparam int AW = $clog2(MEMORY_WORDS);

    logic [SW:0] sum;
    logic [SW:0] wrapped;

    always_comb begin
        sum = {1'b0, i_base} + {1'b0, i_offset};
        if (sum >= (SW+1)'(MEMORY_WORDS)) begin
            wrapped = sum - (SW+1)'(MEMORY_WORDS);
        end else begin
            wrapped = sum;
        end
    end

    assign o_addr = wrapped[AW-1:0];

endmodule

// File: src/text_console_char_writer.sv
// Text console character writer: top level with cursor/scroll sequencer.
// Uses tcw_pkg, tcw_addr_unit and tcw_ram.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_ready    i_in_data   (t_in_item)
//   out       output     o_out_valid / i_out_ready  o_out_data  (t_out_item)
//   cfg       input      i_cfg_we                   i_cfg_wdata (text attribute)
//
// Each item passes decode; a read then waits for the RAM data, a backspace
// away from column zero writes a blank, and a newline or row wrap takes the
// next-row step. A scroll writes a row of COLUMNS fill words; a scroll that
// returns the origin to 0 first copies SCROLL_ROWS*COLUMNS words, one RAM
// read and one write per word. After reset all MEMORY_WORDS words are cleared
// to 0x0700; no item is taken meanwhile. A waiting result holds the sequencer
// only at its last step; the next item may be taken while a result waits.
module text_console_char_writer #(
    parameter int COLUMNS      = tcw_pkg::DEF_COLUMNS,
    parameter int SCROLL_ROWS  = tcw_pkg::DEF_SCROLL_ROWS,
    parameter int MEMORY_WORDS = tcw_pkg::DEF_MEMORY_WORDS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcw_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcw_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata
);

    import tcw_pkg::*;

    localparam int AW       = $clog2(MEMORY_WORDS);
    localparam int SW       = (AW > FIELD_ADDR_W) ? AW : FIELD_ADDR_W;
    localparam int CW       = $clog2(COLUMNS);
    localparam int LAST_OFF = (SCROLL_ROWS - 1) * COLUMNS;
    localparam int RO_W     = $clog2(LAST_OFF + 1);
    localparam int FIT_SPAN = (SCROLL_ROWS + 2) * COLUMNS;
    localparam int SCREEN   = SCROLL_ROWS * COLUMNS;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_BLANK,
        S_NEXT_ROW,
        S_COPY_RD,
        S_COPY_WR,
        S_FILL,
        S_RD_WAIT,
        S_FINISH
    } t_state;

    t_state          r_state,    n_state;
    t_in_item        r_item,     n_item;
    logic [AW-1:0]   r_origin,   n_origin;
    logic [RO_W-1:0] r_row_off,  n_row_off;
    logic [CW-1:0]   r_col,      n_col;
    logic [AW-1:0]   r_cnt,      n_cnt;
    logic [15:0]     r_data,     n_data;
    logic [7:0]      r_attr,     n_attr;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out,      n_out;

    logic [SW-1:0]   u_base;
    logic [SW-1:0]   u_offset;
    logic [AW-1:0]   u_addr;
    logic [SW-1:0]   cur_off;
    logic [SW:0]     fit_sum;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata;
    logic [15:0]     ram_rdata;

    logic [AW+FIELD_ADDR_W-1:0] ext_cursor;
    logic [AW+FIELD_ADDR_W-1:0] ext_origin;

    tcw_addr_unit #(
        .SW           (SW),
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_addr_unit (
        .i_base   (u_base),
        .i_offset (u_offset),
        .o_addr   (u_addr)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (MEMORY_WORDS)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (u_addr),
        .o_rdata (ram_rdata)
    );

    assign cur_off = SW'(r_row_off) + SW'(r_col);
    assign fit_sum = (SW+1)'(r_origin) + (SW+1)'(FIT_SPAN);

    assign ext_cursor = (AW+FIELD_ADDR_W)'(u_addr);
    assign ext_origin = (AW+FIELD_ADDR_W)'(r_origin);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // address unit operands
    always_comb begin
        u_base   = SW'(r_origin);
        u_offset = cur_off;
        unique case (r_state)
            S_DECODE: begin
                if (r_item.command == CMD_READ) begin
                    u_base   = SW'(r_item.read_address);
                    u_offset = '0;
                end
            end
            S_COPY_RD: u_offset = SW'(COLUMNS) + SW'(r_cnt);
            S_FILL:    u_offset = SW'(SCREEN) + SW'(r_cnt);
            default: ;
        endcase
    end

    // memory write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = u_addr;
        ram_wdata = BLANK_WORD;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
            end
            S_DECODE: begin
                if (r_item.command == CMD_WRITE && r_item.char_code != CH_NEWLINE &&
                    r_item.char_code != CH_RETURN && r_item.char_code != CH_BACKSPACE) begin
                    ram_we    = 1'b1;
                    ram_wdata = {r_attr, r_item.char_code};
                end
            end
            S_BLANK: ram_we = 1'b1;
            S_COPY_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = ram_rdata;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = SCROLL_FILL;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_origin    = r_origin;
        n_row_off   = r_row_off;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_data      = r_data;
        n_attr      = i_cfg_we ? i_cfg_wdata : r_attr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(MEMORY_WORDS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_data  = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_item.command == CMD_READ) begin
                    n_state = S_RD_WAIT;
                end else begin
                    unique case (r_item.char_code)
                        CH_NEWLINE: n_state = S_NEXT_ROW;
                        CH_RETURN: begin
                            n_col   = '0;
                            n_state = S_FINISH;
                        end
                        CH_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col   = r_col - CW'(1);
                                n_state = S_BLANK;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        default: begin
                            if (r_col == CW'(COLUMNS - 1)) begin
                                n_col   = '0;
                                n_state = S_NEXT_ROW;
                            end else begin
                                n_col   = r_col + CW'(1);
                                n_state = S_FINISH;
                            end
                        end
                    endcase
                end
            end
            S_BLANK: n_state = S_FINISH;
            S_NEXT_ROW: begin
                n_cnt = '0;
                if (r_row_off != RO_W'(LAST_OFF)) begin
                    n_row_off = r_row_off + RO_W'(COLUMNS);
                    n_state   = S_FINISH;
                end else if (fit_sum <= (SW+1)'(MEMORY_WORDS - 1)) begin
                    n_origin = r_origin + AW'(COLUMNS);
                    n_state  = S_FILL;
                end else begin
                    n_state = S_COPY_RD;
                end
            end
            S_COPY_RD: n_state = S_COPY_WR;
            S_COPY_WR: begin
                if (r_cnt == AW'(SCREEN - 1)) begin
                    n_cnt    = '0;
                    n_origin = '0;
                    n_state  = S_FILL;
                end else begin
                    n_cnt   = r_cnt + AW'(1);
                    n_state = S_COPY_RD;
                end
            end
            S_FILL: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(COLUMNS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FINISH;
                end
            end
            S_RD_WAIT: begin
                n_data  = ram_rdata;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.cursor_address = ext_cursor[FIELD_ADDR_W-1:0];
                    n_out.display_origin = ext_origin[FIELD_ADDR_W-1:0];
                    n_out.read_data      = r_data;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_origin    <= '0;
            r_row_off   <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_origin    <= n_origin;
            r_row_off   <= n_row_off;
            r_col       <= n_col;
            r_cnt       <= n_cnt;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_data <= n_data;
        r_out  <= n_out;
    end

endmodule

// File: tb/text_console_char_writer_test.sv
// Testbench for text_console_char_writer: directed table, then random bursts of text,
// newlines, edits and reads, checked against a cycle-free console predictor.
// Depends on tcw_pkg and the text_console_char_writer RTL.
`timescale 1ns / 1ps

module text_console_char_writer_test;
    import tcw_pkg::*;

    localparam int COLUMNS      = DEF_COLUMNS;
    localparam int SCROLL_ROWS  = DEF_SCROLL_ROWS;
    localparam int MEMORY_WORDS = DEF_MEMORY_WORDS;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int N_DIRECTED   = 21;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    localparam t_out_item NO_WANT = '{13'd0, 13'd0, 16'h0000};

    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{CMD_READ,  8'h00,        13'd0},    1'b1, '{13'd0,   13'd0, BLANK_WORD}},
        '{'{CMD_READ,  8'hFF,        13'd8191}, 1'b1, '{13'd0,   13'd0, BLANK_WORD}},
        '{'{CMD_WRITE, CH_BACKSPACE, 13'd0},    1'b1, '{13'd0,   13'd0, 16'h0000}},
        '{'{CMD_WRITE, 8'h00,        13'h1FFF}, 1'b1, '{13'd1,   13'd0, 16'h0000}},
        '{'{CMD_WRITE, 8'hFF,        13'd0},    1'b1, '{13'd2,   13'd0, 16'h0000}},
        '{'{CMD_READ,  8'h00,        13'd0},    1'b1, '{13'd2,   13'd0, 16'h0E00}},
        '{'{CMD_READ,  8'h00,        13'd1},    1'b1, '{13'd2,   13'd0, 16'h0EFF}},
        '{'{CMD_WRITE, CH_BACKSPACE, 13'd0},    1'b1, '{13'd1,   13'd0, 16'h0000}},
        '{'{CMD_READ,  8'h00,        13'd1},    1'b1, '{13'd1,   13'd0, BLANK_WORD}},
        '{'{CMD_WRITE, CH_RETURN,    13'd0},    1'b1, '{13'd0,   13'd0, 16'h0000}},
        '{'{CMD_WRITE, CH_NEWLINE,   13'd0},    1'b1, '{13'd80,  13'd0, 16'h0000}},
        '{'{CMD_WRITE, 8'h41,        13'd0},    1'b1, '{13'd81,  13'd0, 16'h0000}},
        '{'{CMD_READ,  8'h00,        13'd80},   1'b1, '{13'd81,  13'd0, 16'h0E41}},
        '{'{CMD_WRITE, CH_RETURN,    13'd0},    1'b1, '{13'd80,  13'd0, 16'h0000}},
        '{'{CMD_WRITE, CH_BACKSPACE, 13'd0},    1'b1, '{13'd80,  13'd0, 16'h0000}},
        '{'{CMD_WRITE, CH_NEWLINE,   13'd0},    1'b0, NO_WANT},
        '{'{CMD_WRITE, CH_NEWLINE,   13'd0},    1'b0, NO_WANT},
        '{'{CMD_READ,  8'h00,        13'd1920}, 1'b1, '{13'd240, 13'd0, BLANK_WORD}},
        '{'{CMD_WRITE, 8'h7F,        13'd0},    1'b0, NO_WANT},
        '{'{CMD_WRITE, 8'h80,        13'd0},    1'b0, NO_WANT},
        '{'{CMD_READ,  8'hAA,        13'h1555}, 1'b0, NO_WANT}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    logic      cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    // console predictor state
    logic [15:0] screen_mem [MEMORY_WORDS];
    int          org_w       = 0;
    int          cur_row     = 0;
    int          cur_col     = 0;
    logic [7:0]  attr_shadow = ATTR_RESET;
    int          scroll_count = 0;
    int          origin_returns = 0;

    t_out_item reports_due [$];
    t_out_item report_head;
    int        snd_idle_pct   = 34;
    int        rcv_idle_pct   = 65;
    int        transfers_in   = 0;
    int        results_seen   = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    text_console_char_writer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int cursor_word();
        return (org_w + cur_row * COLUMNS + cur_col) % MEMORY_WORDS;
    endfunction

    task automatic advance_row();
        int i;
        int base;
        cur_row++;
        if (cur_row >= SCROLL_ROWS) begin
            cur_row = SCROLL_ROWS - 1;
            scroll_count++;
            if (org_w + (SCROLL_ROWS + 2) * COLUMNS <= MEMORY_WORDS - 1) begin
                org_w += COLUMNS;
            end else begin
                for (i = 0; i < SCROLL_ROWS * COLUMNS; i++)
                    screen_mem[i % MEMORY_WORDS] = screen_mem[(org_w + COLUMNS + i) % MEMORY_WORDS];
                org_w = 0;
                origin_returns++;
            end
            base = org_w + SCROLL_ROWS * COLUMNS;
            for (i = 0; i < COLUMNS; i++)
                screen_mem[(base + i) % MEMORY_WORDS] = SCROLL_FILL;
        end
    endtask

    task automatic console_apply(input t_in_item it, output t_out_item res);
        logic [15:0] rd;
        rd = 16'h0000;
        if (it.command == CMD_WRITE) begin
            case (it.char_code)
                CH_NEWLINE: advance_row();
                CH_RETURN: cur_col = 0;
                CH_BACKSPACE: begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen_mem[cursor_word()] = BLANK_WORD;
                    end
                end
                default: begin
                    screen_mem[cursor_word()] = {attr_shadow, it.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        advance_row();
                    end
                end
            endcase
        end else begin
            rd = screen_mem[it.read_address];
        end
        res.cursor_address = 13'(cursor_word());
        res.display_origin = 13'(org_w);
        res.read_data      = rd;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic send_item(input t_in_item it, input logic typed, input t_out_item typed_want);
        t_out_item predicted;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        console_apply(it, predicted);
        reports_due.push_back(typed ? typed_want : predicted);
        transfers_in++;
    endtask

    // hold off the sender until every pending result has been transferred
    task automatic drain();
        in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        attr_shadow = value;
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (reports_due.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                report_head = reports_due.pop_front();
                if (out_data.cursor_address !== report_head.cursor_address)
                    report_mismatch($sformatf("cursor_address %0d, want %0d",
                        out_data.cursor_address, report_head.cursor_address));
                if (out_data.display_origin !== report_head.display_origin)
                    report_mismatch($sformatf("display_origin %0d, want %0d",
                        out_data.display_origin, report_head.display_origin));
                if (out_data.read_data !== report_head.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                        out_data.read_data, report_head.read_data));
            end
            results_seen++;
        end
    end

    initial begin
        t_in_item   it;
        logic [7:0] attr_next;
        int         ph;
        int         r;
        int         k;
        int         n;
        int         target;
        int         len;
        int         kind;
        for (r = 0; r < MEMORY_WORDS; r++) screen_mem[r] = BLANK_WORD;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED_ROWS[r].stim, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        drain();

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 34;
                    rcv_idle_pct = 65;
                    attr_next    = 8'hFF;
                    target       = 180;
                end
                1: begin
                    snd_idle_pct = 65;
                    rcv_idle_pct = 34;
                    attr_next    = 8'h00;
                    target       = 180;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    attr_next    = 8'($urandom_range(1, 254));
                    target       = 190;
                end
            endcase
            write_attribute(attr_next);
            n = 0;
            while (n < target) begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2: len = $urandom_range(1, 60);
                    3, 4, 5: len = $urandom_range(5, 30);
                    6:       len = $urandom_range(1, 8);
                    default: len = $urandom_range(1, 6);
                endcase
                if (len > target - n) len = target - n;
                for (k = 0; k < len; k++) begin
                    it.command      = CMD_WRITE;
                    it.read_address = 13'($urandom_range(0, MEMORY_WORDS - 1));
                    case (kind)
                        0, 1, 2: it.char_code = ($urandom_range(0, 9) == 0) ?
                            8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
                        3, 4, 5: it.char_code = CH_NEWLINE;
                        6: begin
                            case ($urandom_range(0, 2))
                                0:       it.char_code = CH_BACKSPACE;
                                1:       it.char_code = CH_RETURN;
                                default: it.char_code = 8'($urandom_range(32, 126));
                            endcase
                        end
                        7, 8: begin
                            it.command   = CMD_READ;
                            it.char_code = 8'($urandom_range(0, 255));
                            case ($urandom_range(0, 3))
                                0: it.read_address = 13'((cursor_word() + MEMORY_WORDS
                                    - $urandom_range(0, 100)) % MEMORY_WORDS);
                                1: it.read_address = 13'((org_w + SCROLL_ROWS * COLUMNS
                                    + $urandom_range(0, COLUMNS - 1)) % MEMORY_WORDS);
                                2: it.read_address = 13'($urandom_range(0,
                                    SCROLL_ROWS * COLUMNS - 1));
                                default: ;
                            endcase
                        end
                        default: begin
                            it.command   = 1'($urandom_range(0, 1));
                            it.char_code = 8'($urandom_range(0, 255));
                        end
                    endcase
                    send_item(it, 1'b0, NO_WANT);
                end
                n += len;
            end
            drain();
        end

        repeat (40) @(posedge clk);
        $display("Covered %0d transfers in and %0d results over three idle patterns",
            transfers_in, results_seen);
        $display("Scrolls: %0d, of which %0d copied rows back to origin 0",
            scroll_count, origin_returns);
        if (mismatch_count == 0 && reports_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: text_console_char_writer.f
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_addr_unit.sv
src/text_console_char_writer.sv
tb/text_console_char_writer_test.sv
